[rtl/mls_pkg.sv]
// ----------------------------------------------------------------------------
// mls_pkg
// Shared types and constants for the markdown line styler: payload structs,
// style flag masks, token codes, character codes and the token list helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mls_pkg;

  // Input item: start-of-document flag and text byte
  typedef struct packed {
    logic       mode;
    logic [7:0] text_byte;
  } mls_in_t;

  // Result item: style token, carried byte, end-of-run mark
  typedef struct packed {
    logic [4:0] token;
    logic [7:0] out_byte;
    logic       last;
  } mls_out_t;

  // Style flags
  localparam int unsigned FLAG_W = 11;
  typedef logic [FLAG_W-1:0] flags_t;

  localparam flags_t F_OVERRIDE  = 11'h001;
  localparam flags_t F_SYN_IN    = 11'h002;
  localparam flags_t F_IDDONE    = 11'h004;
  localparam flags_t F_SYNTAX    = 11'h008;
  localparam flags_t F_HEADER    = 11'h010;
  localparam flags_t F_ITAL      = 11'h020;
  localparam flags_t F_LIST      = 11'h040;
  localparam flags_t F_TAB       = 11'h080;
  localparam flags_t F_ALT       = 11'h100;
  localparam flags_t F_LINK      = 11'h200;
  localparam flags_t F_UNDERLINE = 11'h400;

  // Token codes
  localparam logic [4:0] TOK_LIT     = 5'd0;
  localparam logic [4:0] TOK_DEFAULT = 5'd1;
  localparam logic [4:0] TOK_LIST    = 5'd2;
  localparam logic [4:0] TOK_TAB     = 5'd3;
  localparam logic [4:0] TOK_OSQUARE = 5'd4;
  localparam logic [4:0] TOK_OPAREN  = 5'd5;
  localparam logic [4:0] TOK_ULINE   = 5'd6;
  localparam logic [4:0] TOK_H1      = 5'd7;
  localparam logic [4:0] TOK_H2      = 5'd8;
  localparam logic [4:0] TOK_H3      = 5'd9;
  localparam logic [4:0] TOK_ITALIC  = 5'd10;
  localparam logic [4:0] TOK_BOLD    = 5'd11;
  localparam logic [4:0] TOK_BOLDIT  = 5'd12;
  localparam logic [4:0] TOK_CSQUARE = 5'd13;
  localparam logic [4:0] TOK_CPAREN  = 5'd14;
  localparam logic [4:0] TOK_RESET   = 5'd15;
  localparam logic [4:0] TOK_ALT     = 5'd16;
  localparam logic [4:0] TOK_LINK    = 5'd17;
  localparam logic [4:0] TOK_CODE    = 5'd18;
  localparam logic [4:0] TOK_NLCODE  = 5'd19;

  // Character codes
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LSQ    = 8'h5B;
  localparam logic [7:0] CH_RSQ    = 8'h5D;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_TICK   = 8'h60;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Up to three tokens per item
  localparam logic [1:0] MAX_TOKS = 2'd3;

  typedef struct packed {
    logic [2:0][4:0] toks;
    logic [1:0]      n;
  } tok_buf_t;

  // Append a token, dropping it once the list is full
  function automatic tok_buf_t tb_push(tok_buf_t b, logic [4:0] t);
    tok_buf_t r;
    r = b;
    if (r.n != MAX_TOKS) begin
      r.toks[r.n] = t;
      r.n = r.n + 2'd1;
    end
    return r;
  endfunction

endpackage

[rtl/markdown_line_styler.sv]
// An accepted item is held in the input register, then loaded into the result
//   register, whose tokens are offered one per cycle while result_ready is high.
// Throughput: one item per cycle while items give at most one token and
//   result_ready is high; an item of n tokens (up to 3) stays until all are taken.
// Reset (rst, synchronous): clears style flags, marker count, previous byte
//   and both pipeline valid bits.
// ----------------------------------------------------------------------------
// markdown_line_styler
// Styles markdown text byte by byte into runs of style tokens plus the literal
// byte, tracking headers, emphasis, list/quote marks, links and code spans.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module markdown_line_styler #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  mls_pkg::mls_in_t  item,
  output logic              result_valid,
  input  logic              result_ready,
  output mls_pkg::mls_out_t result
);

  import mls_pkg::*;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  typedef enum logic [2:0] {
    ACT_CONT,
    ACT_LIT,
    ACT_SYN,
    ACT_DEFS,
    ACT_NL
  } act_t;

  typedef struct packed {
    flags_t   flags;
    cnt_t     cnt;
    tok_buf_t tb;
    logic     again;
  } step_t;

  localparam cnt_t CNT_ONE   = cnt_t'(1);
  localparam cnt_t CNT_TWO   = cnt_t'(2);
  localparam cnt_t CNT_THREE = cnt_t'(3);

  // One pass over the byte in plain, override or code mode, then the
  // follow-up action (defaults, newline, code entry or literal)
  function automatic step_t run_pass(step_t si, logic [7:0] c, logic [7:0] prev);
    step_t  s;
    flags_t f;
    act_t   act;
    s = si;
    s.again = 1'b0;
    f = s.flags;
    act = ACT_CONT;
    if ((f & (F_OVERRIDE | F_SYN_IN)) == '0) begin
      case (c)
        CH_HASH: begin
          if ((f & (F_IDDONE | F_SYNTAX)) == '0) begin
            s.cnt = s.cnt + CNT_ONE;
            s.flags = s.flags | F_HEADER;
            act = ACT_CONT;
          end else begin
            act = ((f & F_SYNTAX) != '0) ? ACT_SYN : ACT_LIT;
          end
        end
        CH_STAR: begin
          if ((f & (F_HEADER | F_SYNTAX)) == '0) begin
            s.cnt = s.cnt + CNT_ONE;
            s.flags = s.flags | F_ITAL;
            act = ACT_CONT;
          end else begin
            act = ((f & F_SYNTAX) != '0) ? ACT_SYN : ACT_DEFS;
          end
        end
        CH_DASH, CH_GT, CH_EQ: begin
          if ((f & (F_IDDONE | F_HEADER | F_SYNTAX)) == '0) begin
            if (c == CH_DASH) begin
              s.tb = tb_push(s.tb, TOK_LIST);
              s.flags = s.flags | F_LIST;
            end else if (c == CH_GT) begin
              s.tb = tb_push(s.tb, TOK_TAB);
              s.flags = s.flags | F_TAB;
            end else begin
              s.tb = tb_push(s.tb, TOK_ULINE);
              s.flags = s.flags | F_UNDERLINE;
            end
          end
          if ((f & F_HEADER) != '0) act = ACT_DEFS;
          else if ((f & F_SYNTAX) != '0) act = ACT_SYN;
          else act = ACT_LIT;
        end
        CH_LSQ: begin
          if ((f & (F_HEADER | F_SYNTAX)) == '0) begin
            s.flags = s.flags | F_ALT | F_OVERRIDE;
            s.tb = tb_push(s.tb, TOK_OSQUARE);
            act = ACT_CONT;
          end else begin
            act = ((f & F_SYNTAX) != '0) ? ACT_SYN : ACT_DEFS;
          end
        end
        CH_LPAR: begin
          if ((f & (F_IDDONE | F_HEADER | F_SYNTAX)) == '0 && (f & F_LINK) != '0) begin
            s.flags = s.flags | F_OVERRIDE;
            s.tb = tb_push(s.tb, TOK_OPAREN);
            act = ACT_CONT;
          end else if ((f & F_HEADER) != '0) begin
            act = ACT_DEFS;
          end else if ((f & F_SYNTAX) != '0) begin
            act = ACT_SYN;
          end else begin
            act = ACT_LIT;
          end
        end
        CH_NL: act = ACT_NL;
        CH_SPACE, CH_TAB: act = ACT_LIT;
        CH_TICK: begin
          if ((f & F_HEADER) == '0) begin
            s.flags = s.flags | F_SYNTAX;
            s.cnt = s.cnt + CNT_ONE;
            act = ACT_LIT;
          end else begin
            act = ACT_DEFS;
          end
        end
        default: act = ACT_DEFS;
      endcase
    end else if ((f & F_OVERRIDE) != '0) begin
      // Override: closing brackets, emphasis close, alt/link coloring
      if ((f & F_HEADER) != '0) begin
        act = (c == CH_NL) ? ACT_NL : ACT_LIT;
      end else if (c == CH_RSQ) begin
        s.tb = tb_push(s.tb, TOK_CSQUARE);
        s.flags = F_LINK;
        act = ACT_CONT;
      end else if (c == CH_RPAR && (f & F_ALT) == '0) begin
        s.tb = tb_push(s.tb, TOK_CPAREN);
        s.flags = '0;
        act = ACT_CONT;
      end else if (c == CH_STAR) begin
        s.cnt = s.cnt - CNT_ONE;
        act = ACT_CONT;
      end else begin
        if (s.cnt == '0 && (f & F_ITAL) != '0) begin
          s.tb = tb_push(s.tb, TOK_RESET);
          s.flags = '0;
        end else if ((f & F_ALT) != '0) begin
          s.tb = tb_push(s.tb, TOK_ALT);
        end else if ((f & F_LINK) != '0) begin
          s.tb = tb_push(s.tb, TOK_LINK);
        end
        act = (c == CH_NL) ? ACT_NL : ACT_LIT;
      end
    end else begin
      // Code span: unescaped backtick closes one level
      if (prev != CH_BSLASH && c == CH_TICK) begin
        s.tb = tb_push(s.tb, TOK_DEFAULT);
        s.cnt = s.cnt - CNT_ONE;
        if (s.cnt == '0) s.flags = F_IDDONE;
        act = ACT_LIT;
      end else if (c == CH_NL) begin
        s.tb = tb_push(s.tb, TOK_NLCODE);
        act = ACT_CONT;
      end else begin
        if (s.cnt == '0) s.flags = F_IDDONE;
        act = ACT_LIT;
      end
    end

    // Default styling for content bytes
    if (act == ACT_DEFS) begin
      s.flags = s.flags & ~F_LINK;
      if ((s.flags & F_SYNTAX) != '0) begin
        act = ACT_SYN;
      end else begin
        if ((s.flags & F_HEADER) != '0) begin
          s.flags = s.flags | F_OVERRIDE;
          if (s.cnt == CNT_ONE) s.tb = tb_push(s.tb, TOK_H1);
          else if (s.cnt == CNT_TWO) s.tb = tb_push(s.tb, TOK_H2);
          else s.tb = tb_push(s.tb, TOK_H3);
        end else if ((s.flags & (F_LIST | F_TAB)) != '0) begin
          s.tb = tb_push(s.tb, TOK_DEFAULT);
        end
        if ((s.flags & F_ITAL) != '0) begin
          if (s.cnt == CNT_ONE) s.tb = tb_push(s.tb, TOK_ITALIC);
          else if (s.cnt == CNT_TWO) s.tb = tb_push(s.tb, TOK_BOLD);
          else if (s.cnt == CNT_THREE) s.tb = tb_push(s.tb, TOK_BOLDIT);
          s.flags = s.flags | F_OVERRIDE;
        end
        s.flags = s.flags | F_IDDONE;
        act = ACT_LIT;
      end
    end else if (act == ACT_NL) begin
      if ((s.flags & F_SYNTAX) != '0) begin
        act = ACT_SYN;
      end else begin
        s.flags = '0;
        s.cnt = '0;
        s.tb = tb_push(s.tb, TOK_DEFAULT);
        act = ACT_LIT;
      end
    end

    // Enter code mode and run again, or emit the byte
    if (act == ACT_SYN) begin
      s.flags = s.flags | F_SYN_IN;
      s.tb = tb_push(s.tb, TOK_CODE);
      s.again = 1'b1;
    end else if (act == ACT_LIT) begin
      s.tb = tb_push(s.tb, TOK_LIT);
    end
    return s;
  endfunction

  // Architectural state
  flags_t     flags;
  cnt_t       marker_count;
  logic [7:0] prev_byte;

  // Input register
  logic     s1_valid;
  mls_in_t  s1_item;
  logic     s1_move;

  // Result register: token list drained one per cycle while result_ready is high
  logic            buf_valid;
  logic [2:0][4:0] buf_toks;
  logic [7:0]      buf_byte;
  logic [1:0]      buf_n;
  logic [1:0]      buf_idx;
  logic            buf_last;

  // Next-state computation
  step_t      st_init;
  step_t      st_a;
  step_t      st_b;
  step_t      st_next;
  logic [7:0] prev_byte_next;

  always_comb begin
    st_init = '{flags: flags, cnt: marker_count, tb: '0, again: 1'b0};
    st_a = run_pass(st_init, s1_item.text_byte, prev_byte);
    st_b = st_a.again ? run_pass(st_a, s1_item.text_byte, prev_byte) : st_a;
    prev_byte_next = prev_byte;
    if (s1_item.mode) begin
      st_next = '0;
      st_next.tb = tb_push(tok_buf_t'('0), TOK_DEFAULT);
      prev_byte_next = '0;
    end else if (s1_item.text_byte == '0) begin
      st_next = st_init;
    end else begin
      st_next = st_b;
      prev_byte_next = s1_item.text_byte;
    end
  end

  // Handshake
  assign buf_last     = (buf_idx == (buf_n - 2'd1));
  assign s1_move      = s1_valid && (!buf_valid || (result_ready && buf_last));
  assign item_ready   = !s1_valid || s1_move;
  assign result_valid = buf_valid;

  always_comb begin
    result.token    = buf_toks[buf_idx];
    result.out_byte = (buf_toks[buf_idx] == TOK_LIT) ? buf_byte : 8'd0;
    result.last     = buf_last;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
    if (item_ready && item_valid) begin
      s1_item <= item;
    end
  end

  // State update and result register load/drain
  always_ff @(posedge clk) begin
    if (rst) begin
      flags        <= '0;
      marker_count <= '0;
      prev_byte    <= '0;
      buf_valid    <= 1'b0;
      buf_idx      <= '0;
    end else if (s1_move) begin
      flags        <= st_next.flags;
      marker_count <= st_next.cnt;
      prev_byte    <= prev_byte_next;
      buf_valid    <= (st_next.tb.n != 2'd0);
      buf_idx      <= '0;
    end else if (buf_valid && result_ready) begin
      if (buf_last) begin
        buf_valid <= 1'b0;
      end else begin
        buf_idx <= buf_idx + 2'd1;
      end
    end
    if (s1_move) begin
      buf_toks <= st_next.tb.toks;
      buf_n    <= st_next.tb.n;
      buf_byte <= s1_item.text_byte;
    end
  end

`ifndef SYNTHESIS
  // A held result run is never empty and the index stays inside it
  a_buf_range: assert property (@(posedge clk) disable iff (rst)
    buf_valid |-> (buf_n != 2'd0 && buf_idx < buf_n))
    else $error("result index outside token run");

  // A NUL text byte leaves all style state alone
  a_nul_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_move && !s1_item.mode && s1_item.text_byte == 8'd0) |=>
      (flags == $past(flags) && marker_count == $past(marker_count) &&
       prev_byte == $past(prev_byte)))
    else $error("NUL byte changed styler state");

  // Start of document clears state and gives a single default token
  a_doc_start: assert property (@(posedge clk) disable iff (rst)
    (s1_move && s1_item.mode) |=>
      (flags == '0 && marker_count == '0 && buf_valid && buf_n == 2'd1 &&
       buf_toks[0] == TOK_DEFAULT))
    else $error("start of document not handled");
`endif

endmodule
